/* rtl/core/ptrr_pkg.sv */
// Package for the press timing record/replay block: phase type, defaults, widths.
// Used by the config channel interface and the top level.
package ptrr_pkg;

  localparam int unsigned STORE_DEPTH_DEF = 32;
  localparam int unsigned COUNT_WIDTH_DEF = 16;
  localparam int unsigned IDLE_W          = 16;
  localparam logic [IDLE_W-1:0] IDLE_RESET = 16'd300;
  localparam int unsigned BLINK_W         = 3;
  localparam logic [BLINK_W-1:0] BLINK_TOGGLES = 3'd4;

  typedef enum logic [1:0] {
    PH_WAIT,
    PH_RECORD,
    PH_BLINK,
    PH_REPLAY
  } phase_e;

endpackage

/* rtl/core/ptrr_if.sv */
// Valid/ready channel interfaces: button sample in, LED/status item out, config write.
// Depends on ptrr_pkg.
interface ptrr_in_if;
  logic valid;
  logic ready;
  logic button_level;
  modport source (output valid, output button_level, input ready);
  modport sink   (input valid, input button_level, output ready);
endinterface

interface ptrr_out_if #(
  parameter int unsigned CNT_W = 6
);
  logic             valid;
  logic             ready;
  logic             red_led;
  logic             green_led;
  logic             busy_res;
  logic [CNT_W-1:0] entries_stored;
  modport source (output valid, output red_led, output green_led, output busy_res,
                  output entries_stored, input ready);
  modport sink   (input valid, input red_led, input green_led, input busy_res,
                  input entries_stored, output ready);
endinterface

interface ptrr_cfg_if import ptrr_pkg::*;;
  logic              valid;
  logic              ready;
  logic [IDLE_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/ptrr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ptrr_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/press_timing_record_replay.sv */
// Press timing record/replay: stores press gaps and hold times, replays them on green.
// Output: one result item per input item, registered and valid in the cycle after the item is taken.
// Throughput: one item per cycle while the output is taken; replay prefetches the next entry from the store RAM.
// Reset: async active low; waiting phase, red lit, store empty. Store RAM is not cleared.
// Depends on ptrr_pkg, ptrr_if and ptrr_ram.
module press_timing_record_replay import ptrr_pkg::*; #(
  parameter int unsigned STORE_DEPTH = STORE_DEPTH_DEF,
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF,
  localparam int unsigned SC_W = $clog2(STORE_DEPTH + 1)
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ptrr_in_if.sink     in_i,
  ptrr_out_if.source  out_o,
  ptrr_cfg_if.sink    cfg_i
);

  localparam int unsigned AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int unsigned CMP_W = (COUNT_WIDTH > IDLE_W) ? COUNT_WIDTH : IDLE_W;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  phase_e                 phase_q, phase_d;
  logic [SC_W-1:0]        sc_q, sc_d;
  logic [COUNT_WIDTH-1:0] hold_q, hold_d;
  logic [COUNT_WIDTH-1:0] gap_q, gap_d;
  logic                   run_q, run_d;
  logic                   prev_q, prev_d;
  logic [SC_W-1:0]        ptr_q, ptr_d;
  logic [COUNT_WIDTH-1:0] cd_q, cd_d;
  logic [BLINK_W-1:0]     blink_q, blink_d;
  logic                   red_q, red_d;
  logic                   green_q, green_d;
  logic [IDLE_W-1:0]      idle_q;
  logic [COUNT_WIDTH-1:0] first_q, first_d;

  logic                   out_valid_q;
  logic                   out_red_q, out_green_q, out_busy_q;
  logic [SC_W-1:0]        out_sc_q;

  logic                   we;
  logic [AW-1:0]          waddr;
  logic [COUNT_WIDTH-1:0] wdata;
  logic [AW-1:0]          raddr;
  logic [COUNT_WIDTH-1:0] rdata, rdata_eff;
  logic                   fwd_q;
  logic [COUNT_WIDTH-1:0] fwd_data_q;

  logic                   acc, b;
  logic                   do_chk;
  logic [COUNT_WIDTH-1:0] chk_gap;
  logic [COUNT_WIDTH-1:0] first_val;
  logic [COUNT_WIDTH-1:0] cd_tmp;

  assign acc         = in_i.valid && in_i.ready;
  assign b           = in_i.button_level;
  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign cfg_i.ready = 1'b1;

  assign rdata_eff = fwd_q ? fwd_data_q : rdata;
  assign first_val = (we && (waddr == '0)) ? wdata : first_q;
  assign first_d   = (we && (waddr == '0)) ? wdata : first_q;
  assign raddr     = AW'(ptr_d + SC_W'(1));

  always_comb begin
    phase_d = phase_q;
    sc_d    = sc_q;
    hold_d  = hold_q;
    gap_d   = gap_q;
    run_d   = run_q;
    prev_d  = prev_q;
    ptr_d   = ptr_q;
    cd_d    = cd_q;
    blink_d = blink_q;
    red_d   = red_q;
    green_d = green_q;
    we      = 1'b0;
    waddr   = AW'(sc_q);
    wdata   = gap_q;
    do_chk  = 1'b0;
    chk_gap = gap_q;
    cd_tmp  = cd_q;

    if (acc) begin
      case (phase_q)
        PH_WAIT: begin
          if (prev_q && !b) begin
            red_d = 1'b0;
            if (run_q && (sc_q < SC_W'(STORE_DEPTH))) begin
              we    = 1'b1;
              wdata = gap_q;
              sc_d  = sc_q + SC_W'(1);
            end
            if (sc_d < SC_W'(STORE_DEPTH)) begin
              green_d = 1'b1;
              hold_d  = COUNT_WIDTH'(1);
              phase_d = PH_RECORD;
            end else begin
              blink_d = '0;
              phase_d = PH_BLINK;
            end
          end else begin
            do_chk = 1'b1;
          end
        end
        PH_RECORD: begin
          if (!b) begin
            if (hold_q < CNT_MAX) begin
              hold_d = hold_q + COUNT_WIDTH'(1);
            end
          end else begin
            green_d = 1'b0;
            if (sc_q < SC_W'(STORE_DEPTH)) begin
              we    = 1'b1;
              wdata = hold_q;
              sc_d  = sc_q + SC_W'(1);
            end
            hold_d  = '0;
            phase_d = PH_WAIT;
            gap_d   = '0;
            run_d   = 1'b1;
            chk_gap = '0;
            do_chk  = 1'b1;
          end
        end
        PH_BLINK: begin
          red_d   = !red_q;
          blink_d = blink_q + BLINK_W'(1);
          if (blink_d >= BLINK_TOGGLES) begin
            blink_d = '0;
            phase_d = PH_WAIT;
            gap_d   = '0;
            run_d   = 1'b1;
            chk_gap = '0;
            do_chk  = 1'b1;
          end
        end
        PH_REPLAY: begin
          if (cd_tmp != '0) begin
            cd_tmp = cd_tmp - COUNT_WIDTH'(1);
          end
          cd_d = cd_tmp;
          if (cd_tmp == '0) begin
            ptr_d = ptr_q + SC_W'(1);
            if (ptr_d < sc_q) begin
              green_d = !green_q;
              cd_d    = rdata_eff;
            end else begin
              green_d = 1'b0;
              red_d   = 1'b0;
              sc_d    = '0;
              gap_d   = '0;
              run_d   = 1'b0;
              ptr_d   = '0;
              cd_d    = '0;
              phase_d = PH_WAIT;
            end
          end
        end
        default: begin
          phase_d = PH_WAIT;
        end
      endcase

      if (do_chk && run_d) begin
        if (CMP_W'(chk_gap) == CMP_W'(idle_q)) begin
          phase_d = PH_REPLAY;
          red_d   = 1'b1;
          ptr_d   = '0;
          gap_d   = '0;
          if (sc_d == '0) begin
            green_d = 1'b0;
            red_d   = 1'b0;
            run_d   = 1'b0;
            cd_d    = '0;
            phase_d = PH_WAIT;
          end else begin
            green_d = !green_d;
            cd_d    = first_val;
          end
        end else if (chk_gap < CNT_MAX) begin
          gap_d = chk_gap + COUNT_WIDTH'(1);
        end
      end

      prev_d = b;
    end
  end

  ptrr_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_WAIT;
      sc_q        <= '0;
      hold_q      <= '0;
      gap_q       <= '0;
      run_q       <= 1'b0;
      prev_q      <= 1'b0;
      ptr_q       <= '0;
      cd_q        <= '0;
      blink_q     <= '0;
      red_q       <= 1'b1;
      green_q     <= 1'b0;
      idle_q      <= IDLE_RESET;
      out_valid_q <= 1'b0;
      fwd_q       <= 1'b0;
    end else begin
      phase_q <= phase_d;
      sc_q    <= sc_d;
      hold_q  <= hold_d;
      gap_q   <= gap_d;
      run_q   <= run_d;
      prev_q  <= prev_d;
      ptr_q   <= ptr_d;
      cd_q    <= cd_d;
      blink_q <= blink_d;
      red_q   <= red_d;
      green_q <= green_d;
      fwd_q   <= we && (waddr == raddr);
      if (cfg_i.valid) begin
        idle_q <= cfg_i.data;
      end
      if (acc) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    first_q    <= first_d;
    fwd_data_q <= wdata;
    if (acc) begin
      out_red_q   <= red_d;
      out_green_q <= green_d;
      out_busy_q  <= (phase_d != PH_WAIT);
      out_sc_q    <= sc_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.red_led        = out_red_q;
  assign out_o.green_led      = out_green_q;
  assign out_o.busy_res       = out_busy_q;
  assign out_o.entries_stored = out_sc_q;

  a_sc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sc_q <= SC_W'(STORE_DEPTH))
    else $error("store count beyond depth");

  a_replay_red: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_REPLAY) |-> red_q)
    else $error("red dark during replay");

  a_record_green: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_RECORD) |-> green_q)
    else $error("green dark while recording");

  a_blink_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    blink_q < BLINK_TOGGLES)
    else $error("blink step count overrun");

endmodule
